>>> src/assert_macros.svh
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> src/dgrc_pkg.sv
// shared types, constants and helpers of the graph reachability block
package dgrc_pkg;

  // graph bounds
  localparam int NODES       = 64;
  localparam int TRACK_IDS   = 1024;
  localparam int NODE_W      = $clog2(NODES);
  localparam int TRACK_W     = $clog2(TRACK_IDS);
  localparam int NODE_CNT_W  = $clog2(NODES + 1);
  localparam int TRACK_CNT_W = $clog2(TRACK_IDS + 1);
  localparam int SWEEP_CNT_W = $clog2(NODES + 1);
  localparam int Q_W         = 32;

  // input tdata layout
  localparam int NODE_ID_LSB  = 0;
  localparam int TRACK_ID_LSB = NODE_ID_LSB + NODE_W;
  localparam int SRC_LSB      = TRACK_ID_LSB + TRACK_W;
  localparam int DST_LSB      = SRC_LSB + NODE_W;
  localparam int LEN_LSB      = DST_LSB + NODE_W;
  localparam int SPD_LSB      = LEN_LSB + Q_W;
  localparam int IN_BITS      = SPD_LSB + Q_W;
  localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_BITS   = 3 + NODE_CNT_W + TRACK_CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_ADD_NODE  = 1'b0,
    OP_ADD_TRACK = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // one-hot mask of a node slot
  function automatic logic [NODES-1:0] node_bit(input logic [NODE_W-1:0] idx);
    logic [NODES-1:0] m;
    m      = '0;
    m[idx] = 1'b1;
    return m;
  endfunction

endpackage

>>> src/dgrc_ram.sv
// generic simple dual port ram with registered read
module dgrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/directed_graph_reach_cycle_check.sv
// Directed graph with incrementally kept reachability rows and cycle flag.
// Node adds and track adds failing the field checks go straight to the row sweep; other
// track adds first read the track id in a check state. Requests are taken only when
// idle, the cycle after the result is loaded. The sweep reads one 64-bit row a cycle
// through the row ram port. Reset (synchronous, rst_n low) clears flags, counts and row
// valid bits, then a clearing pass zeroes the track-used ram before requests are taken.
`include "assert_macros.svh"

module directed_graph_reach_cycle_check
  import dgrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // node_id, track_id, source_node, dest_node, track_length, speed_cap, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // accepted, connected, has_cycle, node_total, track_total, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // request fields
  logic [NODE_W-1:0]    in_node;
  logic [TRACK_W-1:0]   in_tid;
  logic [NODE_W-1:0]    in_src;
  logic [NODE_W-1:0]    in_dst;
  logic signed [Q_W-1:0] in_len;
  logic [Q_W-1:0]       in_spd;
  opcode_t              in_op;

  assign in_node = in_tdata[NODE_ID_LSB +: NODE_W];
  assign in_tid  = in_tdata[TRACK_ID_LSB +: TRACK_W];
  assign in_src  = in_tdata[SRC_LSB +: NODE_W];
  assign in_dst  = in_tdata[DST_LSB +: NODE_W];
  assign in_len  = $signed(in_tdata[LEN_LSB +: Q_W]);
  assign in_spd  = in_tdata[SPD_LSB +: Q_W];
  assign in_op   = opcode_t'(in_tuser);

  // control state
  state_t                 state_r, state_nxt;
  logic [TRACK_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [NODES-1:0]       node_present_r, node_present_nxt;
  logic [NODES-1:0]       row_valid_r, row_valid_nxt;
  logic [NODE_CNT_W-1:0]  node_tally_r, node_tally_nxt;
  logic [TRACK_CNT_W-1:0] track_tally_r, track_tally_nxt;
  logic                   cycle_r, cycle_nxt;
  logic [SWEEP_CNT_W-1:0] sweep_cnt_r, sweep_cnt_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   cover_r, cover_nxt;
  logic                   acc_r, acc_nxt;
  logic                   upd_r, upd_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // payload state
  logic [NODE_W-1:0]      u_r, u_nxt;
  logic [NODE_W-1:0]      v_r, v_nxt;
  logic [TRACK_W-1:0]     tid_r, tid_nxt;
  logic [NODE_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [NODES-1:0]       gain_r, gain_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;

  // ram ports
  logic                   row_wr_en;
  logic [NODE_W-1:0]      row_wr_addr;
  logic [NODES-1:0]       row_wr_data;
  logic [NODE_W-1:0]      row_rd_addr;
  logic [NODES-1:0]       row_rd_data;
  logic                   trk_wr_en;
  logic [TRACK_W-1:0]     trk_wr_addr;
  logic [0:0]             trk_wr_data;
  logic [TRACK_W-1:0]     trk_rd_addr;
  logic [0:0]             trk_rd_data;

  // sweep datapath
  logic [NODES-1:0]       row_cur;
  logic [NODES-1:0]       row_new;
  logic                   row_hit;
  logic                   cover_now;
  logic [NODES-1:0]       row_v;
  logic                   connected;

  dgrc_ram #(
    .WIDTH (NODES),
    .DEPTH (NODES)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data),
    .rd_addr (row_rd_addr),
    .rd_data (row_rd_data)
  );

  dgrc_ram #(
    .WIDTH (1),
    .DEPTH (TRACK_IDS)
  ) u_trk_ram (
    .clk     (clk),
    .wr_en   (trk_wr_en),
    .wr_addr (trk_wr_addr),
    .wr_data (trk_wr_data),
    .rd_addr (trk_rd_addr),
    .rd_data (trk_rd_data)
  );

  // row under test in the sweep, merged with the gain when it reaches the source
  always_comb begin
    row_cur   = row_valid_r[rd_idx_r] ? row_rd_data : '0;
    row_hit   = upd_r && ((rd_idx_r == u_r) || row_cur[u_r]);
    row_new   = row_hit ? (row_cur | gain_r) : row_cur;
    cover_now = node_present_r[rd_idx_r] &&
                ((node_present_r & ~(row_new | node_bit(rd_idx_r))) == '0);
    row_v     = row_valid_r[v_r] ? row_rd_data : '0;
    connected = cover_r || (node_tally_r == '0);
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer: next state and ram control
  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    node_present_nxt = node_present_r;
    row_valid_nxt    = row_valid_r;
    node_tally_nxt   = node_tally_r;
    track_tally_nxt  = track_tally_r;
    cycle_nxt        = cycle_r;
    sweep_cnt_nxt    = sweep_cnt_r;
    rd_pend_nxt      = rd_pend_r;
    cover_nxt        = cover_r;
    acc_nxt          = acc_r;
    upd_nxt          = upd_r;
    out_valid_nxt    = out_valid_r;
    u_nxt            = u_r;
    v_nxt            = v_r;
    tid_nxt          = tid_r;
    rd_idx_nxt       = rd_idx_r;
    gain_nxt         = gain_r;
    out_data_nxt     = out_data_r;

    row_wr_en   = 1'b0;
    row_wr_addr = rd_idx_r;
    row_wr_data = row_new;
    row_rd_addr = in_dst;
    trk_wr_en   = 1'b0;
    trk_wr_addr = tid_r;
    trk_wr_data = 1'b1;
    trk_rd_addr = in_tid;

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        trk_wr_en   = 1'b1;
        trk_wr_addr = clr_cnt_r;
        trk_wr_data = 1'b0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == TRACK_W'(TRACK_IDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          u_nxt         = in_src;
          v_nxt         = in_dst;
          tid_nxt       = in_tid;
          sweep_cnt_nxt = '0;
          rd_pend_nxt   = 1'b0;
          cover_nxt     = 1'b0;
          acc_nxt       = 1'b0;
          upd_nxt       = 1'b0;
          state_nxt     = ST_SWEEP;
          if (in_op == OP_ADD_NODE) begin
            if (!node_present_r[in_node]) begin
              node_present_nxt[in_node] = 1'b1;
              node_tally_nxt            = node_tally_r + 1'b1;
              acc_nxt                   = 1'b1;
            end
          end else if (node_present_r[in_src] && node_present_r[in_dst] &&
                       (in_len > 0) && !in_spd[Q_W-1]) begin
            // track id lookup and destination row read are in flight
            state_nxt = ST_CHECK;
          end
        end
      end

      ST_CHECK: begin
        if (!trk_rd_data[0]) begin
          trk_wr_en       = 1'b1;
          track_tally_nxt = track_tally_r + 1'b1;
          acc_nxt         = 1'b1;
          upd_nxt         = 1'b1;
          gain_nxt        = row_v | node_bit(v_r);
          if ((u_r == v_r) || row_v[u_r]) begin
            cycle_nxt = 1'b1;
          end
        end
        state_nxt = ST_SWEEP;
      end

      ST_SWEEP: begin
        // issue one row read a cycle
        if (sweep_cnt_r < SWEEP_CNT_W'(NODES)) begin
          row_rd_addr   = sweep_cnt_r[NODE_W-1:0];
          rd_idx_nxt    = sweep_cnt_r[NODE_W-1:0];
          rd_pend_nxt   = 1'b1;
          sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
        // update and cover test on the row read last cycle
        if (rd_pend_r) begin
          if (row_hit) begin
            row_wr_en               = 1'b1;
            row_valid_nxt[rd_idx_r] = 1'b1;
          end
          if (cover_now) begin
            cover_nxt = 1'b1;
          end
          if (sweep_cnt_r == SWEEP_CNT_W'(NODES)) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({track_tally_r, node_tally_r, cycle_r,
                                       connected, acc_r});
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      node_present_r <= '0;
      row_valid_r    <= '0;
      node_tally_r   <= '0;
      track_tally_r  <= '0;
      cycle_r        <= 1'b0;
      sweep_cnt_r    <= '0;
      rd_pend_r      <= 1'b0;
      cover_r        <= 1'b0;
      acc_r          <= 1'b0;
      upd_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      node_present_r <= node_present_nxt;
      row_valid_r    <= row_valid_nxt;
      node_tally_r   <= node_tally_nxt;
      track_tally_r  <= track_tally_nxt;
      cycle_r        <= cycle_nxt;
      sweep_cnt_r    <= sweep_cnt_nxt;
      rd_pend_r      <= rd_pend_nxt;
      cover_r        <= cover_nxt;
      acc_r          <= acc_nxt;
      upd_r          <= upd_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    tid_r      <= tid_nxt;
    rd_idx_r   <= rd_idx_nxt;
    gain_r     <= gain_nxt;
    out_data_r <= out_data_nxt;
  end

  // checks
  `ASSERT_ALWAYS(a_node_tally, node_tally_r == $countones(node_present_r), "node count mismatch")
  `ASSERT_NEXT(a_cycle_sticky, cycle_r, cycle_r, "cycle flag cleared")
  `ASSERT_NEXT(a_row_valid, row_wr_en, row_valid_r[$past(row_wr_addr)], "written row not valid")
  `ASSERT_NEXT(a_result_held, (state_r == ST_DONE) && out_valid_r && !out_tready, (state_r == ST_DONE) && out_valid_r, "pending result overwritten")

endmodule

>>> sim/directed_graph_reach_cycle_check_tb.sv
// self-checking testbench of the directed graph reachability and cycle block
module directed_graph_reach_cycle_check_tb
  import dgrc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 150;

  // one request as the sender sees it
  typedef struct {
    opcode_t                op;
    logic [NODE_W-1:0]      node_id;
    logic [TRACK_W-1:0]     track_id;
    logic [NODE_W-1:0]      src;
    logic [NODE_W-1:0]      dst;
    logic signed [Q_W-1:0]  len;
    logic signed [Q_W-1:0]  spd;
  } graph_request_t;

  // one result as the block reports it
  typedef struct packed {
    logic                   accepted;
    logic                   connected;
    logic                   has_cycle;
    logic [NODE_CNT_W-1:0]  node_total;
    logic [TRACK_CNT_W-1:0] track_total;
  } graph_status_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // node_id, track_id, source_node, dest_node, track_length, speed_cap, zero pad
  logic [IN_DATA_W-1:0]  in_tdata;
  // opcode
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // accepted, connected, has_cycle, node_total, track_total, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  // predicted graph, all clear as after reset
  bit [NODES-1:0]       node_present_q;
  bit [NODES-1:0]       reach_q [NODES];
  bit                   track_used_q [TRACK_IDS];
  bit [NODE_CNT_W-1:0]  node_count;
  bit [TRACK_CNT_W-1:0] track_count;
  bit                   cycle_flag;

  graph_status_t status_due [$];
  int            fails = 0;
  bit            steady_flow = 1'b0;
  bit            hold_off_req = 1'b0;

  directed_graph_reach_cycle_check u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // some present node reaches every present node, or nothing is present
  function automatic bit graph_covered();
    bit [NODES-1:0] seen;
    if (node_count == 0) return 1'b1;
    for (int s = 0; s < NODES; s++) begin
      if (node_present_q[s]) begin
        seen    = reach_q[s];
        seen[s] = 1'b1;
        if ((node_present_q & ~seen) == '0) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // apply one request to the predicted graph and give the status it reports
  function automatic graph_status_t next_graph_status(input graph_request_t rq);
    graph_status_t  st;
    bit [NODES-1:0] gain;
    bit             taken;
    taken = 1'b0;
    if (rq.op == OP_ADD_NODE) begin
      if (!node_present_q[rq.node_id]) begin
        node_present_q[rq.node_id] = 1'b1;
        node_count++;
        taken = 1'b1;
      end
    end else if (!track_used_q[rq.track_id] && node_present_q[rq.src] &&
                 node_present_q[rq.dst] && rq.len > 0 && rq.spd >= 0) begin
      taken = 1'b1;
      track_used_q[rq.track_id] = 1'b1;
      track_count++;
      // closing a loop: the far end already reaches the near end
      if (rq.src == rq.dst || reach_q[rq.dst][rq.src]) cycle_flag = 1'b1;
      gain         = reach_q[rq.dst];
      gain[rq.dst] = 1'b1;
      // every node reaching the source now also reaches what the sink reaches
      for (int x = 0; x < NODES; x++) begin
        if (x == rq.src || reach_q[x][rq.src]) reach_q[x] |= gain;
      end
    end
    st.accepted    = taken;
    st.connected   = graph_covered();
    st.has_cycle   = cycle_flag;
    st.node_total  = node_count;
    st.track_total = track_count;
    return st;
  endfunction

  // request generators
  function automatic graph_request_t noise_request();
    graph_request_t rq;
    rq.op       = opcode_t'($urandom_range(0, 1));
    rq.node_id  = NODE_W'($urandom);
    rq.track_id = TRACK_W'($urandom);
    rq.src      = NODE_W'($urandom);
    rq.dst      = NODE_W'($urandom);
    rq.len      = $urandom;
    rq.spd      = $urandom;
    return rq;
  endfunction

  function automatic graph_request_t node_request(input int id);
    graph_request_t rq;
    rq         = noise_request();
    rq.op      = OP_ADD_NODE;
    rq.node_id = NODE_W'(id);
    return rq;
  endfunction

  function automatic graph_request_t track_request(input int tid, input int src,
                                                   input int dst, input logic [31:0] len,
                                                   input logic [31:0] spd);
    graph_request_t rq;
    rq          = noise_request();
    rq.op       = OP_ADD_TRACK;
    rq.track_id = TRACK_W'(tid);
    rq.src      = NODE_W'(src);
    rq.dst      = NODE_W'(dst);
    rq.len      = len;
    rq.spd      = spd;
    return rq;
  endfunction

  function automatic int unused_track_id();
    int t;
    do t = $urandom_range(0, TRACK_IDS - 1); while (track_used_q[t]);
    return t;
  endfunction

  function automatic int present_node();
    int n;
    if (node_count == 0) return $urandom_range(0, NODES - 1);
    do n = $urandom_range(0, NODES - 1); while (!node_present_q[n]);
    return n;
  endfunction

  function automatic logic [31:0] good_length();
    case ($urandom_range(0, 19))
      0:       return 32'h0000_0001;
      1:       return 32'h7fff_ffff;
      default: return $urandom_range(1, 32'h7fff_ffff);
    endcase
  endfunction

  function automatic logic [31:0] good_speed();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7fff_ffff;
      default: return $urandom_range(0, 32'h7fff_ffff);
    endcase
  endfunction

  // offer one request, at times after a random gap, and log its prediction
  task automatic send_request(input graph_request_t rq);
    int                   gap;
    logic [IN_DATA_W-1:0] word;
    graph_status_t        due;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < 37)
      gap = $urandom_range(1, ($urandom_range(0, 19) == 0) ? 90 : 4);
    word                             = '0;
    word[NODE_ID_LSB  +: NODE_W]     = rq.node_id;
    word[TRACK_ID_LSB +: TRACK_W]    = rq.track_id;
    word[SRC_LSB      +: NODE_W]     = rq.src;
    word[DST_LSB      +: NODE_W]     = rq.dst;
    word[LEN_LSB      +: Q_W]        = rq.len;
    word[SPD_LSB      +: Q_W]        = rq.spd;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= rq.op;
    do @(posedge clk); while (!in_tready);
    due        = next_graph_status(rq);
    status_due = {status_due, due};
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when asked
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_tready <= steady_flow || ($urandom_range(0, 99) >= 37);
    end
  end

  function automatic void check_field(input string label, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", label, want, got);
      fails++;
    end
  endfunction

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    graph_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_due.size() == 0) begin
        $error("result with no request pending: %h", out_tdata);
        fails++;
      end else begin
        want = status_due.pop_front();
        check_field("accepted", want.accepted, out_tdata[0]);
        check_field("connected", want.connected, out_tdata[1]);
        check_field("has_cycle", want.has_cycle, out_tdata[2]);
        check_field("node_total", want.node_total, out_tdata[3 +: NODE_CNT_W]);
        check_field("track_total", want.track_total,
                    out_tdata[3 + NODE_CNT_W +: TRACK_CNT_W]);
      end
    end
  end

  // empty graph, extreme node slots, duplicate nodes
  task automatic test_empty_graph();
    send_request(track_request(5, 0, 63, 32'h0001_0000, 32'h0001_0000));
    send_request(node_request(0));
    send_request(node_request(63));
    send_request(node_request(0));
    send_request(node_request(63));
  endtask

  // every reason a track is refused, plus a parallel track
  task automatic test_track_rejects();
    send_request(track_request(0, 0, 63, 32'h0000_0001, 32'h0000_0000));
    send_request(track_request(0, 0, 63, 32'h0001_0000, 32'h0001_0000));
    send_request(track_request(1023, 0, 63, 32'h7fff_ffff, 32'h7fff_ffff));
    send_request(track_request(10, 0, 63, 32'h0000_0000, 32'h0001_0000));
    send_request(track_request(11, 0, 63, 32'h8000_0000, 32'h0001_0000));
    send_request(track_request(12, 0, 63, 32'hffff_ffff, 32'h0001_0000));
    send_request(track_request(13, 0, 63, 32'h0001_0000, 32'h8000_0000));
    send_request(track_request(14, 0, 63, 32'h0001_0000, 32'hffff_ffff));
    send_request(track_request(15, 7, 63, 32'h0001_0000, 32'h0001_0000));
    send_request(track_request(16, 0, 7, 32'h0001_0000, 32'h0001_0000));
  endtask

  // sender stops until every result is back
  task automatic test_drain_pause();
    wait_drained();
  endtask

  // tracks only from lower to higher slots, so no loop can form
  task automatic test_acyclic_growth();
    graph_request_t rq;
    int roll, a, b, t;
    for (int i = 0; i < 150; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25 || node_count < 2) begin
        send_request(node_request(($urandom_range(0, 9) == 0) ?
                                  $urandom_range(0, NODES - 1) : $urandom_range(0, 15)));
      end else if (roll < 90) begin
        a = present_node();
        do b = present_node(); while (b == a);
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        send_request(track_request(unused_track_id(), a, b, good_length(), good_speed()));
      end else begin
        rq     = noise_request();
        rq.op  = OP_ADD_TRACK;
        a      = $urandom_range(0, NODES - 2);
        rq.src = NODE_W'(a);
        rq.dst = NODE_W'($urandom_range(a + 1, NODES - 1));
        send_request(rq);
      end
    end
  endtask

  // a loop closed over several hops, then a self-loop
  task automatic test_cycle_detection();
    send_request(node_request(31));
    send_request(track_request(unused_track_id(), 63, 31, good_length(), good_speed()));
    send_request(track_request(unused_track_id(), 31, 0, good_length(), good_speed()));
    send_request(track_request(unused_track_id(), 31, 31, good_length(), good_speed()));
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_output_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_request(track_request(unused_track_id(), present_node(), present_node(),
                                 good_length(), good_speed()));
  endtask

  // any direction, self-loops, noise and node adds over the whole slot range
  task automatic test_random_mix();
    graph_request_t rq;
    int roll, a;
    for (int i = 0; i < 250; i++) begin
      steady_flow = (i >= 100 && i < 160);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_request(node_request($urandom_range(0, NODES - 1)));
      end else if (roll < 30) begin
        send_request(noise_request());
      end else begin
        a = present_node();
        send_request(track_request(unused_track_id(), a,
                                   (roll < 35) ? a : present_node(),
                                   good_length(), good_speed()));
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_graph();
    test_track_rejects();
    test_drain_pause();
    test_acyclic_growth();
    test_cycle_detection();
    test_output_backpressure();
    test_random_mix();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && status_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/dgrc_pkg.sv
src/dgrc_ram.sv
src/directed_graph_reach_cycle_check.sv
sim/directed_graph_reach_cycle_check_tb.sv
